// File: sv/mse_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIPS-subset execute unit.
// No dependencies; used by every other file of the block.
package mse_pkg;

    // operation codes carried in s_tuser
    typedef enum logic [3:0] {
        FN_ADD  = 4'd0,
        FN_SUB  = 4'd1,
        FN_SLL  = 4'd2,
        FN_ADDI = 4'd3,
        FN_BEQ  = 4'd4,
        FN_BNE  = 4'd5,
        FN_J    = 4'd6,
        FN_JAL  = 4'd7,
        FN_JR   = 4'd8
    } mse_func_t;

    localparam int FUNC_W  = 4;
    localparam int IDX_W   = 5;
    localparam int SH_W    = 5;
    localparam int IMM_W   = 16;
    localparam int TGT_W   = 26;
    localparam int PC_W    = 32;
    localparam int OUTV_W  = 32;

    localparam int S_TDATA_W = 64;
    localparam int S_TUSER_W = 4;
    localparam int M_TDATA_W = 72;
    localparam int M_TUSER_W = 2;

    localparam logic [IDX_W-1:0] LINK_REG = 5'd31;
    localparam logic [PC_W-1:0]  PC_STEP  = 32'd4;

    // execute status passed from the execute logic to the top level
    typedef struct packed {
        logic             reg_wr;
        logic [IDX_W-1:0] wr_idx;
        logic             taken;
    } mse_ctl_t;

endpackage

// File: sv/mse_regfile.sv
`timescale 1ns / 1ps
// Register file: flip-flop memory with per-entry valid bits, registered reads
// on two ports and write-through forwarding. Depends on mse_pkg.
module mse_regfile #(
    parameter int REG_COUNT  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_en,
    input  logic [mse_pkg::IDX_W-1:0] rd_s_idx,
    input  logic [mse_pkg::IDX_W-1:0] rd_t_idx,
    input  logic                      wr_en,
    input  logic [mse_pkg::IDX_W-1:0] wr_idx,
    input  logic [DATA_WIDTH-1:0]     wr_data,
    output logic [DATA_WIDTH-1:0]     rs_data,
    output logic [DATA_WIDTH-1:0]     rt_data
);

    localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    logic [DATA_WIDTH-1:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0]  valid_reg;
    logic [DATA_WIDTH-1:0] rs_data_reg;
    logic [DATA_WIDTH-1:0] rt_data_reg;
    logic                  s_in_rng;
    logic                  t_in_rng;
    logic                  s_fwd;
    logic                  t_fwd;

    assign s_in_rng = (int'(rd_s_idx) < REG_COUNT);
    assign t_in_rng = (int'(rd_t_idx) < REG_COUNT);
    // a write landing on the same edge goes straight to the read register
    assign s_fwd    = wr_en && (wr_idx == rd_s_idx);
    assign t_fwd    = wr_en && (wr_idx == rd_t_idx);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            rf_mem[wr_idx[AW-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_idx[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            if (s_fwd)
                rs_data_reg <= wr_data;
            else if (s_in_rng && valid_reg[rd_s_idx[AW-1:0]])
                rs_data_reg <= rf_mem[rd_s_idx[AW-1:0]];
            else
                rs_data_reg <= '0;

            if (t_fwd)
                rt_data_reg <= wr_data;
            else if (t_in_rng && valid_reg[rd_t_idx[AW-1:0]])
                rt_data_reg <= rf_mem[rd_t_idx[AW-1:0]];
            else
                rt_data_reg <= '0;
        end
    end

    assign rs_data = rs_data_reg;
    assign rt_data = rt_data_reg;

endmodule

// File: sv/mse_exec.sv
`timescale 1ns / 1ps
// Combinational execute: result value, register write and next PC for one
// instruction. Depends on mse_pkg.
module mse_exec #(
    parameter int REG_COUNT  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic [mse_pkg::FUNC_W-1:0]  func,
    input  logic [mse_pkg::IDX_W-1:0]   reg_d_index,
    input  logic [mse_pkg::IDX_W-1:0]   reg_s_index,
    input  logic [mse_pkg::SH_W-1:0]    shift_amount,
    input  logic signed [mse_pkg::IMM_W-1:0] immediate_value,
    input  logic [mse_pkg::TGT_W-1:0]   jump_target,
    input  logic [DATA_WIDTH-1:0]       rs_data,
    input  logic [DATA_WIDTH-1:0]       rt_data,
    input  logic [mse_pkg::PC_W-1:0]    pc,
    output logic [mse_pkg::PC_W-1:0]    next_pc,
    output mse_pkg::mse_ctl_t           ctl,
    output logic [DATA_WIDTH-1:0]       wr_data,
    output logic signed [mse_pkg::OUTV_W-1:0] written_value
);

    logic [mse_pkg::PC_W-1:0] seq_pc;
    logic                     want_wr;
    logic [mse_pkg::IDX_W-1:0] widx;
    logic [DATA_WIDTH-1:0]    wval;
    logic                     taken;
    logic                     eq;
    logic signed [63:0]       rs_wide;
    logic signed [63:0]       wval_wide;
    logic                     idx_ok;

    assign seq_pc    = pc + mse_pkg::PC_STEP;
    assign eq        = (rs_data == rt_data);
    // sign-extend from DATA_WIDTH, then keep the low 32 bits
    assign rs_wide   = 64'(signed'(rs_data));
    assign wval_wide = 64'(signed'(wval));

    always_comb
    begin
        want_wr = 1'b0;
        widx    = '0;
        wval    = '0;
        taken   = 1'b0;
        next_pc = seq_pc;
        unique case (mse_pkg::mse_func_t'(func))
            mse_pkg::FN_ADD:
            begin
                want_wr = 1'b1;
                widx    = reg_d_index;
                wval    = rs_data + rt_data;
            end
            mse_pkg::FN_SUB:
            begin
                want_wr = 1'b1;
                widx    = reg_d_index;
                wval    = rs_data - rt_data;
            end
            mse_pkg::FN_SLL:
            begin
                want_wr = 1'b1;
                widx    = reg_d_index;
                wval    = rt_data << shift_amount;
            end
            mse_pkg::FN_ADDI:
            begin
                want_wr = 1'b1;
                widx    = reg_s_index;
                wval    = rt_data + DATA_WIDTH'(immediate_value);
            end
            mse_pkg::FN_BEQ, mse_pkg::FN_BNE:
            begin
                if ((mse_pkg::mse_func_t'(func) == mse_pkg::FN_BEQ) == eq)
                begin
                    taken   = 1'b1;
                    next_pc = pc + mse_pkg::PC_W'(immediate_value);
                end
            end
            mse_pkg::FN_J:
            begin
                taken   = 1'b1;
                next_pc = mse_pkg::PC_W'(jump_target);
            end
            mse_pkg::FN_JAL:
            begin
                want_wr = 1'b1;
                widx    = mse_pkg::LINK_REG;
                wval    = DATA_WIDTH'(seq_pc);
                taken   = 1'b1;
                next_pc = mse_pkg::PC_W'(jump_target);
            end
            mse_pkg::FN_JR:
            begin
                taken   = 1'b1;
                next_pc = rs_wide[mse_pkg::PC_W-1:0];
            end
            default:
            begin
                // unused codes behave as a no-op
                want_wr = 1'b0;
            end
        endcase
    end

    // writes beyond the file are dropped and reported as no write
    assign idx_ok     = (int'(widx) < REG_COUNT);
    assign ctl.reg_wr = want_wr && idx_ok;
    assign ctl.wr_idx = ctl.reg_wr ? widx : '0;
    assign ctl.taken  = taken;
    assign wr_data    = wval;
    assign written_value = ctl.reg_wr ? wval_wide[mse_pkg::OUTV_W-1:0] : '0;

endmodule

// File: sv/mips_subset_execute_unit_top.sv
`timescale 1ns / 1ps
// Top level of the MIPS-subset execute unit: stream ports, instruction stage,
// PC and result register. Depends on mse_pkg, mse_regfile and mse_exec.

// Executes one pre-decoded instruction per cycle while m_tready does not
// stall the result register. A word accepted on the slave side has its
// registers read at that edge. It is executed from the instruction stage and
// lands in the result register, which drives m_tvalid, when it advances.
// Throughput is one word per cycle unless the result side stalls. The execute
// path (one 32-bit add or shift, compare and PC select between the stage and
// result registers) sets the clock; a result written on one edge is forwarded
// into the operand registers of the word accepted on the same edge, so
// dependent instructions follow back to back. s_tready follows m_tready
// combinationally when both stages are full. Registers and PC reset to zero.
module mips_subset_execute_unit_top #(
    parameter int REG_COUNT  = 32,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // reg_d_index, reg_s_index, reg_t_index, shift_amount, immediate_value,
    // jump_target, zero padding
    input  logic [mse_pkg::S_TDATA_W-1:0] s_tdata,
    // func
    input  logic [mse_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_pc, written_index, written_value, zero padding
    output logic [mse_pkg::M_TDATA_W-1:0] m_tdata,
    // reg_written, branch_taken
    output logic [mse_pkg::M_TUSER_W-1:0] m_tuser
);

    logic accept;
    logic advance;

    logic                                stg_valid_reg;
    logic [mse_pkg::FUNC_W-1:0]          stg_func_reg;
    logic [mse_pkg::IDX_W-1:0]           stg_d_reg;
    logic [mse_pkg::IDX_W-1:0]           stg_s_reg;
    logic [mse_pkg::SH_W-1:0]            stg_sh_reg;
    logic signed [mse_pkg::IMM_W-1:0]    stg_imm_reg;
    logic [mse_pkg::TGT_W-1:0]           stg_tgt_reg;

    logic [mse_pkg::PC_W-1:0]            pc_reg;

    logic                                out_valid_reg;
    logic [mse_pkg::PC_W-1:0]            out_pc_reg;
    mse_pkg::mse_ctl_t                   out_ctl_reg;
    logic signed [mse_pkg::OUTV_W-1:0]   out_val_reg;

    logic [DATA_WIDTH-1:0]               rs_data;
    logic [DATA_WIDTH-1:0]               rt_data;
    logic [mse_pkg::PC_W-1:0]            exec_npc;
    mse_pkg::mse_ctl_t                   exec_ctl;
    logic [DATA_WIDTH-1:0]               exec_wr_data;
    logic signed [mse_pkg::OUTV_W-1:0]   exec_val;

    assign advance  = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stg_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    mse_regfile #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rd_s_idx (s_tdata[9:5]),
        .rd_t_idx (s_tdata[14:10]),
        .wr_en    (advance && exec_ctl.reg_wr),
        .wr_idx   (exec_ctl.wr_idx),
        .wr_data  (exec_wr_data),
        .rs_data  (rs_data),
        .rt_data  (rt_data)
    );

    mse_exec #(
        .REG_COUNT  (REG_COUNT),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_exec (
        .func            (stg_func_reg),
        .reg_d_index     (stg_d_reg),
        .reg_s_index     (stg_s_reg),
        .shift_amount    (stg_sh_reg),
        .immediate_value (stg_imm_reg),
        .jump_target     (stg_tgt_reg),
        .rs_data         (rs_data),
        .rt_data         (rt_data),
        .pc              (pc_reg),
        .next_pc         (exec_npc),
        .ctl             (exec_ctl),
        .wr_data         (exec_wr_data),
        .written_value   (exec_val)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            if (accept)
                stg_valid_reg <= 1'b1;
            else if (advance)
                stg_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
                pc_reg <= exec_npc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stg_func_reg <= s_tuser[3:0];
            stg_d_reg    <= s_tdata[4:0];
            stg_s_reg    <= s_tdata[9:5];
            stg_sh_reg   <= s_tdata[19:15];
            stg_imm_reg  <= s_tdata[35:20];
            stg_tgt_reg  <= s_tdata[61:36];
        end
        if (advance)
        begin
            out_pc_reg  <= exec_npc;
            out_ctl_reg <= exec_ctl;
            out_val_reg <= exec_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_val_reg, out_ctl_reg.wr_idx, out_pc_reg};
    assign m_tuser  = {out_ctl_reg.taken, out_ctl_reg.reg_wr};

endmodule

// File: sv/mse_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the execute unit, bound to the top level.
// Depends on mse_pkg and mips_subset_execute_unit_top.
module mse_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [mse_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [mse_pkg::M_TUSER_W-1:0] m_tuser
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    // with the result register empty the block can always take a word
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty result register");

    // a result appearing from empty traces back to an accepted input word
    a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result appeared without a matching input word");

    // no write reported means index and value read as zero
    a_nowrite_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> (m_tdata[68:32] == '0))
        else $error("written index or value non-zero without a write");

endmodule

bind mips_subset_execute_unit_top mse_checker u_mse_checker (.*);
